// ===== rtl/per_host_flood_detector_top_defines.svh =====
// Assertion macros shared by the flood detector RTL.
// Included by modules that check their own logic; depends on nothing.
`ifndef PER_HOST_FLOOD_DETECTOR_TOP_DEFINES_SVH
`define PER_HOST_FLOOD_DETECTOR_TOP_DEFINES_SVH
// Checks an implication on every clock edge outside reset.
`define PHFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks an implication on every clock edge, reset included.
`define PHFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/phfd_pkg.sv =====
// Package for the per-host flood detector: payload types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package phfd_pkg;
  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic       pass;
    logic [2:0] cause;
  } out_item_t;

  localparam logic [2:0] CAUSE_OK        = 3'd0;
  localparam logic [2:0] CAUSE_UNTRACKED = 3'd1;
  localparam logic [2:0] CAUSE_FULL      = 3'd2;
  localparam logic [2:0] CAUSE_ICMP      = 3'd3;
  localparam logic [2:0] CAUSE_SYN       = 3'd4;
  localparam logic [2:0] CAUSE_SCAN      = 3'd5;

  localparam logic [1:0] REG_ICMP_LIMIT = 2'd0;
  localparam logic [1:0] REG_SYN_LIMIT  = 2'd1;
  localparam logic [1:0] REG_SCAN_LIMIT = 2'd2;
  localparam logic [1:0] REG_IDLE       = 2'd3;

  localparam logic [7:0]  MIN_FRAME  = 8'd34;
  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [7:0]  IHL_MASK   = 8'h0F;
  localparam logic [7:0]  SYN_BIT    = 8'h02;
  localparam logic [7:0]  ETH_HDR    = 8'd14;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  // One queue entry: either a sweep or a classified frame summary.
  typedef struct packed {
    logic        sweep;
    logic        tracked;
    logic        syn_check;
    logic [7:0]  proto;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] now;
  } job_t;
endpackage

// ===== rtl/per_host_flood_detector_top.sv =====
// Per-host flood detector: a byte-stream parser feeds a four-entry job queue that a host
// table engine drains. A frame byte or sweep transfer is accepted when start is high and busy
// is low, at most one per cycle. Each frame's verdict shows on pass/cause with done high for
// one cycle; the job passes the parser's job register, the queue, and the table's lookup and
// update states before done rises, and waits longer when jobs queue ahead of it; the
// receiver cannot hold a verdict off. The table engine handles each job as a lookup, then an
// update, so when a frame end or sweep is taken while another job waits, busy rises until
// the backlog drains.
`timescale 1ns / 1ps
module per_host_flood_detector_top #(
  parameter int HOST_SLOTS  = 16,
  parameter int TALLY_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  phfd_pkg::in_item_t   item,
  output logic                 done,
  output phfd_pkg::out_item_t  result,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  logic [15:0] icmp_max;
  logic [15:0] syn_max;
  logic [15:0] scan_max;
  logic [31:0] idle_interval;

  logic           take;
  logic           pj_valid;
  phfd_pkg::job_t pj;
  logic           q_valid;
  phfd_pkg::job_t q_job;
  logic           q_pop;
  logic           q_full;

  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      icmp_max      <= 16'd100;
      syn_max       <= 16'd100;
      scan_max      <= 16'd20;
      idle_interval <= 32'd1000;
      busy          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          phfd_pkg::REG_ICMP_LIMIT: icmp_max <= cfg_data[15:0];
          phfd_pkg::REG_SYN_LIMIT:  syn_max <= cfg_data[15:0];
          phfd_pkg::REG_SCAN_LIMIT: scan_max <= cfg_data[15:0];
          phfd_pkg::REG_IDLE:       idle_interval <= cfg_data;
          default: ;
        endcase
      end
      // Jobs in flight: parser stage plus queue; stall before both could overflow.
      busy <= q_full || (pj_valid && q_valid) || (take && (item.operation || item.last)
              && q_valid);
    end
  end

  phfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .job_valid (pj_valid),
    .job       (pj)
  );

  phfd_queue #(.DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pj_valid),
    .push_job  (pj),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .full      (q_full)
  );

  phfd_table #(.HOST_SLOTS(HOST_SLOTS), .TALLY_WIDTH(TALLY_WIDTH)) u_table (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (q_valid),
    .job           (q_job),
    .job_pop       (q_pop),
    .icmp_max      (icmp_max),
    .syn_max       (syn_max),
    .scan_max      (scan_max),
    .idle_interval (idle_interval),
    .result_valid  (done),
    .result        (result)
  );
endmodule

// ===== rtl/phfd_parser.sv =====
// Front end: captures header fields from the byte stream and classifies each frame.
// Depends on phfd_pkg; emits one job per sweep and per frame end.
`timescale 1ns / 1ps
module phfd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  phfd_pkg::in_item_t item,
  output logic               job_valid,
  output phfd_pkg::job_t     job
);
  logic [7:0]  byte_index;
  logic [15:0] ether_kind;
  logic [3:0]  header_words;
  logic [7:0]  proto_code;
  logic [31:0] source_addr;
  logic [15:0] dest_port;
  logic [7:0]  tcp_flag_bits;

  logic [7:0]  base;
  logic [7:0]  len;
  logic [15:0] ether_now;
  logic [3:0]  hw_now;
  logic [7:0]  proto_now;
  logic [31:0] addr_now;
  logic [15:0] port_now;
  logic [7:0]  flags_now;
  logic [8:0]  tcp_need;

  always_comb begin
    base      = phfd_pkg::ETH_HDR + {2'd0, header_words, 2'd0};
    ether_now = ether_kind;
    hw_now    = header_words;
    proto_now = proto_code;
    addr_now  = source_addr;
    port_now  = dest_port;
    flags_now = tcp_flag_bits;
    if (byte_index == 8'd12) ether_now[15:8] = item.data_byte;
    if (byte_index == 8'd13) ether_now[7:0] = item.data_byte;
    if (byte_index == 8'd14) hw_now = item.data_byte[3:0];
    if (byte_index == 8'd23) proto_now = item.data_byte;
    if (byte_index == 8'd26) addr_now[31:24] = item.data_byte;
    if (byte_index == 8'd27) addr_now[23:16] = item.data_byte;
    if (byte_index == 8'd28) addr_now[15:8] = item.data_byte;
    if (byte_index == 8'd29) addr_now[7:0] = item.data_byte;
    if (byte_index > phfd_pkg::ETH_HDR) begin
      if (byte_index == base + 8'd2) port_now[15:8] = item.data_byte;
      if (byte_index == base + 8'd3) port_now[7:0] = item.data_byte;
      if (byte_index == base + 8'd13) flags_now = item.data_byte;
    end
    len      = (byte_index == 8'd255) ? 8'd255 : byte_index + 8'd1;
    tcp_need = 9'd28 + {3'd0, hw_now, 2'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      ether_kind    <= '0;
      header_words  <= '0;
      proto_code    <= '0;
      source_addr   <= '0;
      dest_port     <= '0;
      tcp_flag_bits <= '0;
      job_valid     <= 1'b0;
    end else begin
      job_valid <= take && (item.operation || item.last);
      if (take && !item.operation) begin
        if (item.last) begin
          byte_index    <= '0;
          ether_kind    <= '0;
          header_words  <= '0;
          proto_code    <= '0;
          source_addr   <= '0;
          dest_port     <= '0;
          tcp_flag_bits <= '0;
        end else begin
          byte_index    <= len;
          ether_kind    <= ether_now;
          header_words  <= hw_now;
          proto_code    <= proto_now;
          source_addr   <= addr_now;
          dest_port     <= port_now;
          tcp_flag_bits <= flags_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job.sweep     <= item.operation;
      job.tracked   <= (len >= phfd_pkg::MIN_FRAME) && (ether_now == phfd_pkg::ETHER_IPV4);
      job.syn_check <= ({1'b0, len} >= tcp_need) && ((flags_now & phfd_pkg::SYN_BIT) != 8'd0);
      job.proto     <= proto_now;
      job.addr      <= addr_now;
      job.port      <= port_now;
      job.now       <= item.now;
    end
  end
endmodule

// ===== rtl/phfd_queue.sv =====
// Short job queue between the parser and the host table engine.
// Depends on phfd_pkg for the job type.
`timescale 1ns / 1ps
`include "per_host_flood_detector_top_defines.svh"
module phfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  phfd_pkg::job_t push_job,
  input  logic           pop,
  output logic           pop_valid,
  output phfd_pkg::job_t pop_job,
  output logic           full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  phfd_pkg::job_t    entries [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  assign pop_valid = (count != '0);
  assign pop_job   = entries[rd_ptr];
  assign full      = (count == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  `PHFD_ASSERT(a_no_overflow, push |-> !full || pop, "queue overflow")
  `PHFD_ASSERT(a_no_underflow, pop |-> pop_valid, "queue underflow")
  `PHFD_ASSERT(a_count_bound, count <= (AW+1)'(DEPTH), "queue count out of range")
endmodule

// ===== rtl/phfd_table.sv =====
// Back end: host table lookup, allocation, tallies, limits and the expiry sweep.
// Depends on phfd_pkg; processes each queued job in a lookup state, then an action state.
`timescale 1ns / 1ps
`include "per_host_flood_detector_top_defines.svh"
module phfd_table #(
  parameter int HOST_SLOTS  = 16,
  parameter int TALLY_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  phfd_pkg::job_t    job,
  output logic              job_pop,
  input  logic [15:0]       icmp_max,
  input  logic [15:0]       syn_max,
  input  logic [15:0]       scan_max,
  input  logic [31:0]       idle_interval,
  output logic              result_valid,
  output phfd_pkg::out_item_t result
);
  localparam int SW = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
  localparam logic [TALLY_WIDTH-1:0] TOP = '1;

  typedef enum logic [1:0] {
    S_LOOK = 2'b01,
    S_ACT  = 2'b10
  } state_t;

  state_t state;
  logic [HOST_SLOTS-1:0]  slot_valid;
  logic [31:0]            slot_addr  [HOST_SLOTS];
  logic [31:0]            slot_seen  [HOST_SLOTS];
  logic [TALLY_WIDTH-1:0] syn_tally  [HOST_SLOTS];
  logic [TALLY_WIDTH-1:0] icmp_tally [HOST_SLOTS];
  logic [TALLY_WIDTH-1:0] scan_tally [HOST_SLOTS];
  logic [15:0]            prior_port [HOST_SLOTS];

  logic [HOST_SLOTS-1:0] hit_vec;
  logic [HOST_SLOTS-1:0] expire_vec;
  logic                  hit_any;
  logic                  free_any;
  logic [SW-1:0]         hit_idx;
  logic [SW-1:0]         free_idx;

  logic          r_hit;
  logic          r_free;
  logic [SW-1:0] r_slot;

  logic [TALLY_WIDTH-1:0] icmp_cur;
  logic [TALLY_WIDTH-1:0] syn_cur;
  logic [TALLY_WIDTH-1:0] scan_cur;
  logic [15:0]            port_cur;
  logic [TALLY_WIDTH-1:0] icmp_inc;
  logic [TALLY_WIDTH-1:0] syn_inc;
  logic [TALLY_WIDTH-1:0] scan_inc;

  logic [TALLY_WIDTH-1:0] icmp_new;
  logic [TALLY_WIDTH-1:0] syn_new;
  logic [TALLY_WIDTH-1:0] scan_new;
  logic [15:0]            port_new;
  logic [2:0]             cause_next;
  logic                   slot_write;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    hit_any  = 1'b0;
    free_any = 1'b0;
    for (int i = 0; i < HOST_SLOTS; i++) begin
      hit_vec[i]    = slot_valid[i] && (slot_addr[i] == job.addr);
      expire_vec[i] = slot_valid[i] && ((job.now - slot_seen[i]) > idle_interval);
    end
    for (int i = HOST_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    icmp_cur = r_hit ? icmp_tally[r_slot] : '0;
    syn_cur  = r_hit ? syn_tally[r_slot] : '0;
    scan_cur = r_hit ? scan_tally[r_slot] : '0;
    port_cur = r_hit ? prior_port[r_slot] : '0;
    icmp_inc = (icmp_cur == TOP) ? TOP : icmp_cur + 1'b1;
    syn_inc  = (syn_cur == TOP) ? TOP : syn_cur + 1'b1;
    scan_inc = (scan_cur == TOP) ? TOP : scan_cur + 1'b1;
  end

  always_comb begin
    icmp_new   = icmp_cur;
    syn_new    = syn_cur;
    scan_new   = scan_cur;
    port_new   = port_cur;
    cause_next = phfd_pkg::CAUSE_OK;
    slot_write = job.tracked && (r_hit || r_free);
    if (!job.tracked) begin
      cause_next = phfd_pkg::CAUSE_UNTRACKED;
    end else if (!r_hit && !r_free) begin
      cause_next = phfd_pkg::CAUSE_FULL;
    end else if (job.proto == phfd_pkg::PROTO_ICMP) begin
      icmp_new = icmp_inc;
      if (32'(icmp_inc) > 32'(icmp_max)) cause_next = phfd_pkg::CAUSE_ICMP;
    end else if (job.proto == phfd_pkg::PROTO_TCP && job.syn_check) begin
      syn_new = syn_inc;
      if (32'(syn_inc) > 32'(syn_max)) begin
        cause_next = phfd_pkg::CAUSE_SYN;
      end else if (port_cur != job.port) begin
        scan_new = scan_inc;
        port_new = job.port;
        if (32'(scan_inc) > 32'(scan_max)) cause_next = phfd_pkg::CAUSE_SCAN;
      end
    end
  end

  assign job_pop = job_valid && (state == S_ACT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOOK;
      slot_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_ACT) && !job.sweep;
      unique case (state)
        S_LOOK: begin
          if (job_valid) state <= S_ACT;
        end
        S_ACT: begin
          state <= S_LOOK;
          if (job.sweep) begin
            slot_valid <= slot_valid & ~expire_vec;
          end else if (job.tracked && !r_hit && r_free) begin
            slot_valid[r_slot] <= 1'b1;
          end
        end
        default: state <= S_LOOK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      r_hit  <= hit_any;
      r_free <= free_any;
      r_slot <= hit_any ? hit_idx : free_idx;
    end
    if (state == S_ACT && job_valid && !job.sweep) begin
      result.pass  <= (cause_next != phfd_pkg::CAUSE_ICMP) &&
                      (cause_next != phfd_pkg::CAUSE_SYN) &&
                      (cause_next != phfd_pkg::CAUSE_SCAN);
      result.cause <= cause_next;
      if (slot_write) begin
        slot_addr[r_slot]  <= job.addr;
        slot_seen[r_slot]  <= job.now;
        icmp_tally[r_slot] <= icmp_new;
        syn_tally[r_slot]  <= syn_new;
        scan_tally[r_slot] <= scan_new;
        prior_port[r_slot] <= port_new;
      end
    end
  end

  `PHFD_ASSERT(a_hit_unique, job_valid |-> $onehot0(hit_vec), "host address held by two slots")
  `PHFD_ASSERT(a_pop_in_act, job_pop |-> state == S_ACT, "job popped outside action cycle")
  `PHFD_ASSERT(a_result_after_pop, result_valid |-> $past(job_pop) && !$past(job.sweep),
    "result without a frame job")
endmodule

// ===== bench/per_host_flood_detector_top_test.sv =====
// Self-checking bench for the per-host flood detector: drives frame bytes and sweeps,
// predicts every verdict with its own host table model and compares pass and cause.
// Depends on phfd_pkg and per_host_flood_detector_top.
`timescale 1ns / 1ps
module per_host_flood_detector_top_test;
  localparam int SLOTS = 16;
  localparam int TALLY_MAX = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  phfd_pkg::in_item_t item = '0;
  logic done;
  phfd_pkg::out_item_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  per_host_flood_detector_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [15:0] lim_icmp, lim_syn, lim_scan;
  logic [31:0] lim_idle;
  logic [7:0] pos;
  logic [15:0] etype, dport;
  logic [3:0] ihl;
  logic [7:0] proto, flags;
  logic [31:0] saddr;
  logic hv[SLOTS];
  logic [31:0] haddr[SLOTS], hseen[SLOTS];
  logic [15:0] hsyn[SLOTS], hicmp[SLOTS], hscan[SLOTS], hport[SLOTS];

  phfd_pkg::out_item_t verdicts_due[$];
  phfd_pkg::in_item_t pending[$];
  int errors = 0;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == TALLY_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [2:0] judge(logic [7:0] len, logic [31:0] now);
    int s;
    s = -1;
    if (len < phfd_pkg::MIN_FRAME || etype != phfd_pkg::ETHER_IPV4)
      return phfd_pkg::CAUSE_UNTRACKED;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && hv[i] && haddr[i] == saddr) begin
        s = i;
        hseen[i] = now;
      end
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && !hv[i]) begin
        s = i;
        hv[i] = 1'b1;
        haddr[i] = saddr;
        hseen[i] = now;
        hsyn[i] = '0; hicmp[i] = '0; hscan[i] = '0; hport[i] = '0;
      end
    if (s < 0) return phfd_pkg::CAUSE_FULL;
    if (proto == phfd_pkg::PROTO_ICMP) begin
      hicmp[s] = sat_inc(hicmp[s]);
      if (hicmp[s] > lim_icmp) return phfd_pkg::CAUSE_ICMP;
    end else if (proto == phfd_pkg::PROTO_TCP) begin
      if (int'(len) >= 2 * phfd_pkg::ETH_HDR + 4 * ihl &&
          (flags & phfd_pkg::SYN_BIT) != 0) begin
        hsyn[s] = sat_inc(hsyn[s]);
        if (hsyn[s] > lim_syn) return phfd_pkg::CAUSE_SYN;
        if (hport[s] != dport) begin
          hscan[s] = sat_inc(hscan[s]);
          hport[s] = dport;
          if (hscan[s] > lim_scan) return phfd_pkg::CAUSE_SCAN;
        end
      end
    end
    return phfd_pkg::CAUSE_OK;
  endfunction

  task automatic predict(phfd_pkg::in_item_t it);
    int base;
    logic [7:0] len;
    phfd_pkg::out_item_t r;
    base = phfd_pkg::ETH_HDR + 4 * ihl;
    if (it.operation) begin
      for (int i = 0; i < SLOTS; i++)
        if (hv[i] && (it.now - hseen[i]) > lim_idle) hv[i] = 1'b0;
      return;
    end
    case (pos)
      8'd12: etype[15:8] = it.data_byte;
      8'd13: etype[7:0] = it.data_byte;
      8'd14: ihl = it.data_byte[3:0];
      8'd23: proto = it.data_byte;
      8'd26: saddr[31:24] = it.data_byte;
      8'd27: saddr[23:16] = it.data_byte;
      8'd28: saddr[15:8] = it.data_byte;
      8'd29: saddr[7:0] = it.data_byte;
      default: ;
    endcase
    if (pos > phfd_pkg::ETH_HDR) begin
      if (pos == base + 2) dport[15:8] = it.data_byte;
      if (pos == base + 3) dport[7:0] = it.data_byte;
      if (pos == base + 13) flags = it.data_byte;
    end
    len = (pos == 8'd255) ? 8'd255 : pos + 8'd1;
    pos = len;
    if (!it.last) return;
    r.cause = judge(len, it.now);
    r.pass = (r.cause >= phfd_pkg::CAUSE_ICMP) ? 1'b0 : 1'b1;
    verdicts_due.push_back(r);
    pos = '0; etype = '0; ihl = '0; proto = '0; saddr = '0; dport = '0; flags = '0;
  endtask

  // Set at each rising edge that completes an input transfer.
  bit took = 1'b0;

  // Driver: one item per transfer, random gap before each following one.
  int gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || took) begin
        if (gap > 0) begin
          start <= 1'b0;
          gap--;
        end else if (pending.size() > 0) begin
          item <= pending.pop_front();
          start <= 1'b1;
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst && start && !busy) predict(item);
  end

  always @(posedge clk) begin
    phfd_pkg::out_item_t exp_r;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict with none expected: pass %0d cause %0d", result.pass, result.cause);
        errors++;
      end else begin
        exp_r = verdicts_due.pop_front();
        if (result.pass !== exp_r.pass) begin
          $error("pass: expected %0d actual %0d", exp_r.pass, result.pass);
          errors++;
        end
        if (result.cause !== exp_r.cause) begin
          $error("cause: expected %0d actual %0d", exp_r.cause, result.cause);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending.size() > 0 || start) @(posedge clk);
    while (verdicts_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      phfd_pkg::REG_ICMP_LIMIT: lim_icmp = val[15:0];
      phfd_pkg::REG_SYN_LIMIT: lim_syn = val[15:0];
      phfd_pkg::REG_SCAN_LIMIT: lim_scan = val[15:0];
      default: lim_idle = val;
    endcase
  endtask

  function automatic phfd_pkg::in_item_t mk(logic op, logic [7:0] b, logic lst,
                                            logic [31:0] t);
    phfd_pkg::in_item_t it;
    it.operation = op;
    it.data_byte = b;
    it.last = lst;
    it.now = t;
    return it;
  endfunction

  logic [31:0] clock_tick = 0;

  // Queue a frame; ip selects a well-formed IPv4 header with the given fields.
  task automatic push_frame(int len, bit ip, logic [3:0] hl, logic [7:0] pr,
                            logic [31:0] src, logic [15:0] port, logic [7:0] fl);
    logic [7:0] b;
    int base;
    base = phfd_pkg::ETH_HDR + 4 * hl;
    for (int p = 0; p < len; p++) begin
      b = 8'($urandom);
      if (ip) begin
        if (p == 12) b = 8'h08;
        if (p == 13) b = 8'h00;
        if (p == 14) b = {4'h4, hl};
        if (p == 23) b = pr;
        if (p >= 26 && p <= 29) b = src[8 * (29 - p) +: 8];
        if (p > phfd_pkg::ETH_HDR && p == base + 2) b = port[15:8];
        if (p > phfd_pkg::ETH_HDR && p == base + 3) b = port[7:0];
        if (p > phfd_pkg::ETH_HDR && p == base + 13) b = fl;
      end
      clock_tick += $urandom_range(0, 3);
      pending.push_back(mk(1'b0, b, p == len - 1, clock_tick));
    end
  endtask

  task automatic push_sweep(logic [31:0] adv);
    clock_tick += adv;
    pending.push_back(mk(1'b1, 8'($urandom), 1'($urandom), clock_tick));
  endtask

  int queued;
  int n;
  logic [7:0] pr;
  initial begin
    lim_icmp = 16'd100; lim_syn = 16'd100; lim_scan = 16'd20; lim_idle = 32'd1000;
    pos = '0; etype = '0; ihl = '0; proto = '0; saddr = '0; dport = '0; flags = '0;
    for (int i = 0; i < SLOTS; i++) hv[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: short, non-IPv4, ICMP, SYN, port change, odd header, long frame, sweep.
    write_reg(phfd_pkg::REG_ICMP_LIMIT, 32'd1);
    write_reg(phfd_pkg::REG_SYN_LIMIT, 32'd2);
    write_reg(phfd_pkg::REG_SCAN_LIMIT, 32'd0);
    write_reg(phfd_pkg::REG_IDLE, 32'd0);
    push_frame(1, 0, 0, 0, 0, 0, 0);
    push_frame(33, 1, 5, phfd_pkg::PROTO_ICMP, 32'h0A000001, 0, 0);
    push_frame(40, 0, 5, 0, 0, 0, 0);
    push_frame(34, 1, 5, phfd_pkg::PROTO_ICMP, 32'hFFFFFFFF, 0, 0);
    push_frame(34, 1, 5, phfd_pkg::PROTO_ICMP, 32'hFFFFFFFF, 0, 0);
    push_frame(54, 1, 5, phfd_pkg::PROTO_TCP, 32'h0, 16'hFFFF, 8'hFF);
    push_frame(54, 1, 5, phfd_pkg::PROTO_TCP, 32'h0, 16'h1234, phfd_pkg::SYN_BIT);
    push_frame(54, 1, 5, phfd_pkg::PROTO_TCP, 32'h0, 16'h1234, phfd_pkg::SYN_BIT);
    push_frame(60, 1, 2, phfd_pkg::PROTO_TCP, 32'h1, 16'h8000, phfd_pkg::SYN_BIT);
    push_frame(120, 1, 15, phfd_pkg::PROTO_TCP, 32'h2, 16'h0001, phfd_pkg::SYN_BIT);
    push_frame(260, 1, 5, 8'd17, 32'h3, 0, 0);
    push_sweep(32'hFFFF_0000);
    for (int h = 0; h < 18; h++) push_frame(34, 1, 5, 8'd17, 32'hC0A80000 + h, 0, 0);
    wait_drained();
    push_sweep(32'd5);
    wait_drained();

    // Random phases with changing limits.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(phfd_pkg::REG_ICMP_LIMIT, ph == 5 ? 32'hFFFF : $urandom_range(0, 8));
      write_reg(phfd_pkg::REG_SYN_LIMIT, ph == 5 ? 32'hFFFF : $urandom_range(0, 8));
      write_reg(phfd_pkg::REG_SCAN_LIMIT, ph == 5 ? 32'hFFFF : $urandom_range(0, 6));
      write_reg(phfd_pkg::REG_IDLE, ph == 4 ? 32'hFFFFFFFF : $urandom_range(0, 400));
      queued = 0;
      while (queued < 80) begin
        case ($urandom_range(0, 9))
          0: begin
            push_sweep($urandom_range(0, 500));
            queued++;
          end
          1: begin
            n = $urandom_range(1, 40);
            push_frame(n, 0, 0, 0, 0, 0, 0);
            queued += n;
          end
          default: begin
            n = $urandom_range(34, 60);
            pr = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                 ($urandom_range(0, 1) ? phfd_pkg::PROTO_TCP : phfd_pkg::PROTO_ICMP);
            push_frame(n, 1, $urandom_range(0, 1) ? 4'd5 : 4'($urandom),
                       pr, 32'hC0A80000 + $urandom_range(0, 24),
                       16'($urandom_range(0, 3)) ^
                       ($urandom_range(0, 7) == 0 ? 16'hFFFF : 16'h0000),
                       8'($urandom) | ($urandom_range(0, 3) ? phfd_pkg::SYN_BIT : 8'h00));
            queued += n;
          end
        endcase
      end
      wait_drained();
    end
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/phfd_pkg.sv
rtl/phfd_parser.sv
rtl/phfd_queue.sv
rtl/phfd_table.sv
rtl/per_host_flood_detector_top.sv
bench/per_host_flood_detector_top_test.sv
